// ===== hw/rtl/imh_pkg.sv =====
// Package for the indexed min-heap: sizes, codes, entry and request types.
// No dependencies; used by every other file of the block.
`timescale 1ns / 1ps
`default_nettype none
package imh_pkg;

  localparam int CAPACITY  = 256;
  localparam int KEY_W     = 8;
  localparam int KEY_SPACE = 2 ** KEY_W;
  localparam int COST_W    = 32;
  localparam int POS_W     = $clog2(CAPACITY);
  localparam int CNT_W     = POS_W + 1;
  localparam int ACT_W     = 2;
  localparam int STAT_W    = 3;

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT   = 2'd0,
    ACT_EXTRACT  = 2'd1,
    ACT_DECREASE = 2'd2
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE   = 3'd0,
    ST_MIN    = 3'd1,
    ST_EMPTY  = 3'd2,
    ST_REJECT = 3'd3,
    ST_FULL   = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_DEC_CHK,
    S_UP_RD,
    S_UP_CMP,
    S_PLACE,
    S_EX_TOP,
    S_DN_RD,
    S_DN_SEL,
    S_DN_CMP,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic        [KEY_W-1:0]  key;
    logic signed [COST_W-1:0] cost;
  } slot_t;

  typedef struct packed {
    logic             we;
    logic [POS_W-1:0] waddr;
    slot_t            wdata;
    logic [POS_W-1:0] raddr_a;
    logic [POS_W-1:0] raddr_b;
  } slot_req_t;

  typedef struct packed {
    logic [KEY_W-1:0] raddr;
    logic             we;
    logic [KEY_W-1:0] wkey;
    logic [POS_W-1:0] wpos;
    logic             clr;
    logic [KEY_W-1:0] clr_key;
  } pos_req_t;

  typedef struct packed {
    logic             valid;
    logic [POS_W-1:0] pos;
  } pos_rd_t;

  typedef struct packed {
    status_t                  status;
    logic        [KEY_W-1:0]  key;
    logic signed [COST_W-1:0] cost;
  } result_t;

endpackage
`default_nettype wire

// ===== hw/rtl/imh_in_if.sv =====
// Request channel of the indexed min-heap: valid/ready plus one operation.
// Depends on imh_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface imh_in_if import imh_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic        [ACT_W-1:0]  action;
  logic        [KEY_W-1:0]  item_key;
  logic signed [COST_W-1:0] item_cost;

  modport source (output valid, action, item_key, item_cost, input ready);
  modport sink (input valid, action, item_key, item_cost, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/imh_out_if.sv =====
// Response channel of the indexed min-heap: valid/ready plus one result.
// Depends on imh_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface imh_out_if import imh_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic        [STAT_W-1:0] status;
  logic        [KEY_W-1:0]  min_key;
  logic signed [COST_W-1:0] min_cost;

  modport source (output valid, status, min_key, min_cost, input ready);
  modport sink (input valid, status, min_key, min_cost, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/imh_slot_ram.sv =====
// Heap slot storage: one write port, two registered read ports.
// Depends on imh_pkg.
`timescale 1ns / 1ps
`default_nettype none
module imh_slot_ram import imh_pkg::*; (
  input  wire logic      clk,
  input  wire slot_req_t req,
  output slot_t          rd_a,
  output slot_t          rd_b
);

  slot_t mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_a <= mem[req.raddr_a];
    rd_b <= mem[req.raddr_b];
  end

endmodule
`default_nettype wire

// ===== hw/rtl/imh_pos_map.sv =====
// Key-to-slot map: position memory plus per-key present bits cleared by reset.
// Depends on imh_pkg.
`timescale 1ns / 1ps
`default_nettype none
module imh_pos_map import imh_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire pos_req_t req,
  output pos_rd_t       rd
);

  logic [POS_W-1:0]     mem [KEY_SPACE];
  logic [KEY_SPACE-1:0] present;

  always_ff @(posedge clk) begin
    if (rst) begin
      present <= '0;
    end else begin
      if (req.we) begin
        present[req.wkey] <= 1'b1;
      end
      if (req.clr) begin
        present[req.clr_key] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.wkey] <= req.wpos;
    end
    rd.pos   <= mem[req.raddr];
    rd.valid <= present[req.raddr];
  end

endmodule
`default_nettype wire

// ===== hw/rtl/imh_ctrl.sv =====
// Heap sequencer: walks sift-up and sift-down one level at a time around a
// single shared signed cost comparator. Depends on imh_pkg.
`timescale 1ns / 1ps
`default_nettype none
module imh_ctrl import imh_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic        [ACT_W-1:0]  in_action,
  input  wire logic        [KEY_W-1:0]  in_key,
  input  wire logic signed [COST_W-1:0] in_cost,
  input  wire slot_t                    slot_rd_a,
  input  wire slot_t                    slot_rd_b,
  output slot_req_t                     slot_req,
  input  wire pos_rd_t                  pos_rd,
  output pos_req_t                      pos_req,
  output logic                          res_valid,
  input  wire logic                     res_ready,
  output result_t                       res
);

  state_t           state, state_next;
  action_t          act, act_next;
  slot_t            mov, mov_next;
  slot_t            sel, sel_next;
  logic [POS_W-1:0] pos, pos_next;
  logic [POS_W-1:0] sel_pos, sel_pos_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [CNT_W-1:0] ch, ch_next;
  result_t          res_next;

  logic signed [COST_W-1:0] cmp_a, cmp_b;
  logic                     cmp_lt;
  logic                     key_ok;
  logic [POS_W-1:0]         parent;
  logic [CNT_W-1:0]         child;
  logic [CNT_W-1:0]         right;

  assign cmp_lt = cmp_a < cmp_b;
  assign key_ok = 32'(in_key) < CAPACITY;
  assign parent = (pos - POS_W'(1)) >> 1;
  assign child  = {pos, 1'b1};
  assign right  = ch + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    act     <= act_next;
    mov     <= mov_next;
    sel     <= sel_next;
    pos     <= pos_next;
    sel_pos <= sel_pos_next;
    ch      <= ch_next;
    res     <= res_next;
  end

  always_comb begin
    state_next   = state;
    act_next     = act;
    mov_next     = mov;
    sel_next     = sel;
    pos_next     = pos;
    sel_pos_next = sel_pos;
    cnt_next     = cnt;
    ch_next      = ch;
    res_next     = res;
    in_ready     = 1'b0;
    res_valid    = 1'b0;
    cmp_a        = mov.cost;
    cmp_b        = slot_rd_a.cost;
    slot_req     = '0;
    pos_req      = '0;

    unique case (state)
      S_IDLE: begin
        in_ready     = 1'b1;
        pos_req.raddr = in_key;
        if (in_valid) begin
          act_next      = action_t'(in_action);
          mov_next.key  = in_key;
          mov_next.cost = in_cost;
          res_next      = '{status: ST_REJECT, key: '0, cost: '0};
          priority case (action_t'(in_action))
            ACT_INSERT, ACT_DECREASE: begin
              state_next = key_ok ? S_CHECK : S_RESULT;
            end
            ACT_EXTRACT: begin
              if (cnt == '0) begin
                res_next.status = ST_EMPTY;
                state_next      = S_RESULT;
              end else begin
                slot_req.raddr_a = '0;
                slot_req.raddr_b = POS_W'(cnt - CNT_W'(1));
                state_next       = S_EX_TOP;
              end
            end
            default: begin
              state_next = S_RESULT;
            end
          endcase
        end
      end

      S_CHECK: begin
        if (act == ACT_INSERT) begin
          if (pos_rd.valid) begin
            state_next = S_RESULT;
          end else if (cnt == CNT_W'(CAPACITY)) begin
            res_next.status = ST_FULL;
            state_next      = S_RESULT;
          end else begin
            pos_next   = POS_W'(cnt);
            cnt_next   = cnt + CNT_W'(1);
            state_next = S_UP_RD;
          end
        end else begin
          if (!pos_rd.valid) begin
            state_next = S_RESULT;
          end else begin
            pos_next         = pos_rd.pos;
            slot_req.raddr_a = pos_rd.pos;
            state_next       = S_DEC_CHK;
          end
        end
      end

      S_DEC_CHK: begin
        state_next = cmp_lt ? S_UP_RD : S_RESULT;
      end

      S_UP_RD: begin
        if (pos == '0) begin
          state_next = S_PLACE;
        end else begin
          slot_req.raddr_a = parent;
          state_next       = S_UP_CMP;
        end
      end

      S_UP_CMP: begin
        if (cmp_lt) begin
          slot_req.we    = 1'b1;
          slot_req.waddr = pos;
          slot_req.wdata = slot_rd_a;
          pos_req.we     = 1'b1;
          pos_req.wkey   = slot_rd_a.key;
          pos_req.wpos   = pos;
          pos_next       = parent;
          state_next     = S_UP_RD;
        end else begin
          state_next = S_PLACE;
        end
      end

      S_PLACE: begin
        slot_req.we     = 1'b1;
        slot_req.waddr  = pos;
        slot_req.wdata  = mov;
        pos_req.we      = 1'b1;
        pos_req.wkey    = mov.key;
        pos_req.wpos    = pos;
        res_next.status = (act == ACT_EXTRACT) ? ST_MIN : ST_DONE;
        state_next      = S_RESULT;
      end

      S_EX_TOP: begin
        res_next.key    = slot_rd_a.key;
        res_next.cost   = slot_rd_a.cost;
        res_next.status = ST_MIN;
        pos_req.clr     = 1'b1;
        pos_req.clr_key = slot_rd_a.key;
        cnt_next        = cnt - CNT_W'(1);
        mov_next        = slot_rd_b;
        pos_next        = '0;
        state_next      = (cnt == CNT_W'(1)) ? S_RESULT : S_DN_RD;
      end

      S_DN_RD: begin
        if (child >= cnt) begin
          state_next = S_PLACE;
        end else begin
          slot_req.raddr_a = child[POS_W-1:0];
          slot_req.raddr_b = POS_W'(child + CNT_W'(1));
          ch_next          = child;
          state_next       = S_DN_SEL;
        end
      end

      S_DN_SEL: begin
        cmp_a = slot_rd_b.cost;
        cmp_b = slot_rd_a.cost;
        if (right < cnt && cmp_lt) begin
          sel_next     = slot_rd_b;
          sel_pos_next = POS_W'(right);
        end else begin
          sel_next     = slot_rd_a;
          sel_pos_next = ch[POS_W-1:0];
        end
        state_next = S_DN_CMP;
      end

      S_DN_CMP: begin
        cmp_a = sel.cost;
        cmp_b = mov.cost;
        if (cmp_lt) begin
          slot_req.we    = 1'b1;
          slot_req.waddr = pos;
          slot_req.wdata = sel;
          pos_req.we     = 1'b1;
          pos_req.wkey   = sel.key;
          pos_req.wpos   = pos;
          pos_next       = sel_pos;
          state_next     = S_DN_RD;
        end else begin
          state_next = S_PLACE;
        end
      end

      S_RESULT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/indexed_min_heap.sv =====
// Indexed binary min-heap with key-to-slot map; insert, extract-min, decrease.
// Insert and decrease sift the entry up until a compare stops it or it is the root;
// extract moves the last entry to the root and sifts it down, or ends if it was the
// only entry; empty or rejected ops leave the heap unchanged.
// One op in flight, the next after its result is taken; up to two slot reads per step.
// Reset clears the key map's present bits and the count.
`timescale 1ns / 1ps
`default_nettype none
module indexed_min_heap import imh_pkg::*; (
  input wire logic  clk,
  input wire logic  rst,
  imh_in_if.sink    in_ch,
  imh_out_if.source out_ch
);

  slot_req_t slot_req;
  slot_t     slot_rd_a, slot_rd_b;
  pos_req_t  pos_req;
  pos_rd_t   pos_rd;
  logic      res_valid, res_ready;
  result_t   res;
  logic      out_valid;
  result_t   out_beat;

  imh_slot_ram u_slot_ram (
    .clk  (clk),
    .req  (slot_req),
    .rd_a (slot_rd_a),
    .rd_b (slot_rd_b)
  );

  imh_pos_map u_pos_map (
    .clk (clk),
    .rst (rst),
    .req (pos_req),
    .rd  (pos_rd)
  );

  imh_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_action (in_ch.action),
    .in_key    (in_ch.item_key),
    .in_cost   (in_ch.item_cost),
    .slot_rd_a (slot_rd_a),
    .slot_rd_b (slot_rd_b),
    .slot_req  (slot_req),
    .pos_rd    (pos_rd),
    .pos_req   (pos_req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !out_valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_beat <= res;
    end
  end

  assign out_ch.valid    = out_valid;
  assign out_ch.status   = out_beat.status;
  assign out_ch.min_key  = out_beat.key;
  assign out_ch.min_cost = out_beat.cost;

endmodule
`default_nettype wire
